@@ design/mlps_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mlps_pkg;

    // configuration register indexes
    typedef enum logic [15:0] {
        REG_OBJ_R   = 16'd0,
        REG_OBJ_G   = 16'd1,
        REG_OBJ_B   = 16'd2,
        REG_CAM_X   = 16'd3,
        REG_CAM_Y   = 16'd4,
        REG_CAM_Z   = 16'd5,
        REG_LCOUNT  = 16'd6
    } reg_index_t;

    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_SHADE = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_NSQ,
        ST_NLEN,
        ST_NDIV,
        ST_VSQ,
        ST_VLEN,
        ST_VDIV,
        ST_RD,
        ST_LDIFF,
        ST_LSQ,
        ST_LLEN,
        ST_LDIV,
        ST_ATT,
        ST_HSUM,
        ST_HSQ,
        ST_HLEN,
        ST_HDIV,
        ST_DOTS,
        ST_POW,
        ST_INT,
        ST_TERMS,
        ST_ACC,
        ST_SCALE,
        ST_OUT
    } state_t;

    // divider request
    typedef struct packed {
        logic        start;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quot;
    } div_rsp_t;

    // square root request
    typedef struct packed {
        logic        start;
        logic [63:0] rad;
    } sqrt_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] root;
    } sqrt_rsp_t;

endpackage
`default_nettype wire

@@ design/mlps_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mlps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

@@ design/mlps_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mlps_div (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire mlps_pkg::div_req_t req,
    output mlps_pkg::div_rsp_t    rsp
);

    logic [63:0] rem_reg, rem_next;
    logic [63:0] quo_reg, quo_next;
    logic [63:0] den_reg;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [64:0] trial;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[63]} - {1'b0, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[64])
            begin
                rem_next = trial[63:0];
                quo_next = {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_next = {rem_reg[62:0], quo_reg[63]};
                quo_next = {quo_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign rsp.busy = busy_reg;
    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;

endmodule
`default_nettype wire

@@ design/mlps_sqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none
module mlps_sqrt (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire mlps_pkg::sqrt_req_t req,
    output mlps_pkg::sqrt_rsp_t     rsp
);

    logic [63:0] x_reg, x_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // digit-by-digit root, two radicand bits per cycle
    always_comb
    begin
        x_next    = x_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            x_next    = req.rad;
            res_next  = '0;
            bit_next  = 64'h4000_0000_0000_0000;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (x_reg >= res_reg + bit_reg)
            begin
                x_next   = x_reg - (res_reg + bit_reg);
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[31:0];

endmodule
`default_nettype wire

@@ design/multi_light_pixel_shader.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Blinn-Phong shader over a light table held in three small synchronous RAMs
// (position, color, radius). A load beat writes one entry.
// A shade beat normalizes the normal and view vector, then for each light reads
// its entry, normalizes the light and half vectors, divides for attenuation and
// raises the specular term through nine squarings. Every square root runs on a
// shared 32-step unit and every quotient on a shared 64-step divider, so the
// length of a shade beat grows with the light count and is set by those two
// iterative units. Only one beat is in flight; the result register holds a
// finished pixel while the next beat is accepted. Entries read before being
// written give undefined pixels.
module multi_light_pixel_shader #(
    parameter int MAX_LIGHTS = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        kind,
    input  wire logic [2:0]  light_index,
    input  wire logic signed [15:0] pos_x,
    input  wire logic signed [15:0] pos_y,
    input  wire logic signed [15:0] pos_z,
    input  wire logic [15:0] light_red,
    input  wire logic [15:0] light_green,
    input  wire logic [15:0] light_blue,
    input  wire logic [15:0] light_reach,
    input  wire logic signed [15:0] normal_x,
    input  wire logic signed [15:0] normal_y,
    input  wire logic signed [15:0] normal_z,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       pixel_red,
    output logic [7:0]       pixel_green,
    output logic [7:0]       pixel_blue
);

    localparam int AW = (MAX_LIGHTS > 1) ? $clog2(MAX_LIGHTS) : 1;
    localparam int CW = $clog2(MAX_LIGHTS + 1);

    // configuration registers
    logic [15:0] obj_reg [3];
    logic signed [15:0] cam_reg [3];
    logic [3:0]  lcount_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            obj_reg[0] <= 16'd32768;
            obj_reg[1] <= 16'd32768;
            obj_reg[2] <= 16'd32768;
            cam_reg[0] <= '0;
            cam_reg[1] <= '0;
            cam_reg[2] <= '0;
            lcount_reg <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case ({13'd0, cfg_index})
                mlps_pkg::REG_OBJ_R:  obj_reg[0] <= cfg_data;
                mlps_pkg::REG_OBJ_G:  obj_reg[1] <= cfg_data;
                mlps_pkg::REG_OBJ_B:  obj_reg[2] <= cfg_data;
                mlps_pkg::REG_CAM_X:  cam_reg[0] <= cfg_data;
                mlps_pkg::REG_CAM_Y:  cam_reg[1] <= cfg_data;
                mlps_pkg::REG_CAM_Z:  cam_reg[2] <= cfg_data;
                mlps_pkg::REG_LCOUNT: lcount_reg <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // effective light count
    logic [CW-1:0] nlights;
    always_comb
    begin
        priority if (lcount_reg == 4'd0)
            nlights = CW'(1);
        else if (32'(lcount_reg) > MAX_LIGHTS)
            nlights = CW'(MAX_LIGHTS);
        else
            nlights = CW'(lcount_reg);
    end

    mlps_pkg::state_t state_reg, state_next;
    logic in_fire, out_fire;
    logic load_fire, shade_fire;
    logic idx_ok;

    assign in_ready   = (state_reg == mlps_pkg::ST_IDLE);
    assign in_fire    = in_valid && in_ready;
    assign out_fire   = out_valid && out_ready;
    assign idx_ok     = (32'(light_index) < MAX_LIGHTS);
    assign load_fire  = in_fire && (kind == mlps_pkg::KIND_LOAD);
    assign shade_fire = in_fire && (kind == mlps_pkg::KIND_SHADE);

    // light table memories
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [47:0]   pos_rd, col_rd;
    logic [15:0]   rad_rd;
    logic [CW-1:0] li_reg, li_next;

    assign ram_waddr = AW'(light_index);
    assign ram_raddr = AW'(li_reg);

    mlps_ram #(.WIDTH(48), .DEPTH(MAX_LIGHTS)) u_pos_ram (
        .clk(clk), .we(load_fire && idx_ok), .waddr(ram_waddr),
        .wdata({pos_x, pos_y, pos_z}), .raddr(ram_raddr), .rdata(pos_rd)
    );
    mlps_ram #(.WIDTH(48), .DEPTH(MAX_LIGHTS)) u_col_ram (
        .clk(clk), .we(load_fire && idx_ok), .waddr(ram_waddr),
        .wdata({light_red, light_green, light_blue}), .raddr(ram_raddr),
        .rdata(col_rd)
    );
    mlps_ram #(.WIDTH(16), .DEPTH(MAX_LIGHTS)) u_rad_ram (
        .clk(clk), .we(load_fire && idx_ok), .waddr(ram_waddr),
        .wdata(light_reach), .raddr(ram_raddr), .rdata(rad_rd)
    );

    // shared iterative units
    mlps_pkg::div_req_t  dreq;
    mlps_pkg::div_rsp_t  drsp;
    mlps_pkg::sqrt_req_t sreq;
    mlps_pkg::sqrt_rsp_t srsp;

    mlps_div  u_div  (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));
    mlps_sqrt u_sqrt (.clk(clk), .rst_n(rst_n), .req(sreq), .rsp(srsp));

    // datapath registers
    logic signed [15:0] frag_reg [3];
    logic signed [17:0] vec_reg [3];     // vector being normalized
    logic signed [15:0] nu_reg [3];
    logic signed [15:0] vu_reg [3];
    logic signed [15:0] lu_reg [3];
    logic signed [15:0] hu_reg [3];
    logic signed [15:0] tmp_reg [3];     // normalize results
    logic [35:0]        sumsq_reg;
    logic [1:0]         k_reg;           // component counter
    logic [31:0]        len_reg;
    logic [34:0]        dsq_reg;
    logic [15:0]        lrad_reg;
    logic [47:0]        lcol_reg;
    logic [31:0]        att_reg;
    logic [17:0]        angle_reg;
    logic [14:0]        blinn_reg;
    logic [3:0]         sq_reg;
    logic [49:0]        inten_reg [3];
    logic [63:0]        prod_reg;
    logic [40:0]        total_reg [3];
    logic [7:0]         pix_reg [3];
    logic               div_wait_reg;
    logic               out_valid_reg;

    // shared helpers
    logic [16:0] mag_cur;
    logic signed [17:0] vcur;
    assign vcur    = vec_reg[k_reg];
    assign mag_cur = vcur[17] ? 17'(-vcur) : 17'(vcur);

    logic [15:0] q_mag;
    assign q_mag = drsp.quot[15:0];

    // dot products (one multiplier per term, registered afterwards)
    logic signed [33:0] dot_nl, dot_nh;
    assign dot_nl = 34'(nu_reg[0] * lu_reg[0]) + 34'(nu_reg[1] * lu_reg[1])
                  + 34'(nu_reg[2] * lu_reg[2]);
    assign dot_nh = 34'(nu_reg[0] * hu_reg[0]) + 34'(nu_reg[1] * hu_reg[1])
                  + 34'(nu_reg[2] * hu_reg[2]);

    logic [15:0] lcol_k, obj_k;
    assign lcol_k = (k_reg == 2'd0) ? lcol_reg[47:32] :
                    (k_reg == 2'd1) ? lcol_reg[31:16] : lcol_reg[15:0];
    assign obj_k  = obj_reg[k_reg];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mlps_pkg::ST_IDLE:  if (shade_fire) state_next = mlps_pkg::ST_PREP;
            mlps_pkg::ST_PREP:  state_next = mlps_pkg::ST_NSQ;
            mlps_pkg::ST_NSQ, mlps_pkg::ST_VSQ, mlps_pkg::ST_LSQ, mlps_pkg::ST_HSQ:
                if (k_reg == 2'd2) state_next = mlps_pkg::state_t'(state_reg + 5'd1);
            mlps_pkg::ST_NLEN, mlps_pkg::ST_VLEN, mlps_pkg::ST_LLEN, mlps_pkg::ST_HLEN:
                if (srsp.done) state_next = mlps_pkg::state_t'(state_reg + 5'd1);
            mlps_pkg::ST_NDIV:
                if (k_reg == 2'd2 && (len_reg == 0 || drsp.done))
                    state_next = mlps_pkg::ST_VSQ;
            mlps_pkg::ST_VDIV:
                if (k_reg == 2'd2 && (len_reg == 0 || drsp.done))
                    state_next = mlps_pkg::ST_RD;
            mlps_pkg::ST_RD:    state_next = mlps_pkg::ST_LDIFF;
            mlps_pkg::ST_LDIFF: state_next = mlps_pkg::ST_LSQ;
            mlps_pkg::ST_LDIV:
                if (k_reg == 2'd2 && (len_reg == 0 || drsp.done))
                    state_next = mlps_pkg::ST_ATT;
            mlps_pkg::ST_ATT:
                if (dsq_reg == 0 || drsp.done) state_next = mlps_pkg::ST_HSUM;
            mlps_pkg::ST_HSUM:  state_next = mlps_pkg::ST_HSQ;
            mlps_pkg::ST_HDIV:
                if (k_reg == 2'd2 && (len_reg == 0 || drsp.done))
                    state_next = mlps_pkg::ST_DOTS;
            mlps_pkg::ST_DOTS:  state_next = mlps_pkg::ST_POW;
            mlps_pkg::ST_POW:   if (sq_reg == 4'd9) state_next = mlps_pkg::ST_INT;
            mlps_pkg::ST_INT:   state_next = mlps_pkg::ST_TERMS;
            mlps_pkg::ST_TERMS: state_next = mlps_pkg::ST_ACC;
            mlps_pkg::ST_ACC:
                if (k_reg == 2'd2)
                    state_next = (li_reg + CW'(1) == nlights) ? mlps_pkg::ST_SCALE
                                                              : mlps_pkg::ST_RD;
                else
                    state_next = mlps_pkg::ST_INT;
            mlps_pkg::ST_SCALE:
                if (k_reg == 2'd2 && drsp.done) state_next = mlps_pkg::ST_OUT;
            mlps_pkg::ST_OUT:
                if (!out_valid_reg || out_ready) state_next = mlps_pkg::ST_IDLE;
            default: state_next = mlps_pkg::ST_IDLE;
        endcase
    end

    // unit requests
    logic div_go;
    always_comb
    begin
        li_next    = li_reg;
        sreq.start = 1'b0;
        sreq.rad   = 64'(sumsq_reg);
        dreq.start = 1'b0;
        dreq.num   = 64'(mag_cur) << 14;
        dreq.den   = 64'(len_reg);
        div_go     = !div_wait_reg && !drsp.busy;
        unique case (state_reg)
            mlps_pkg::ST_NLEN, mlps_pkg::ST_VLEN, mlps_pkg::ST_LLEN, mlps_pkg::ST_HLEN:
                sreq.start = !div_wait_reg;
            mlps_pkg::ST_NDIV, mlps_pkg::ST_VDIV, mlps_pkg::ST_LDIV, mlps_pkg::ST_HDIV:
                dreq.start = div_go && (len_reg != 0);
            mlps_pkg::ST_ATT:
            begin
                dreq.start = div_go && (dsq_reg != 0);
                dreq.num   = 64'(lrad_reg) << 24;
                dreq.den   = 64'(dsq_reg);
            end
            mlps_pkg::ST_SCALE:
            begin
                dreq.start = div_go;
                dreq.num   = 64'(total_reg[k_reg]) * 64'd255;
                dreq.den   = 64'(nlights) << 16;
            end
            mlps_pkg::ST_IDLE:  li_next = '0;
            mlps_pkg::ST_ACC:
                if (k_reg == 2'd2) li_next = li_reg + CW'(1);
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mlps_pkg::ST_IDLE;
            li_reg        <= '0;
            k_reg         <= '0;
            div_wait_reg  <= 1'b0;
            sq_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            li_reg    <= li_next;
            if (state_reg == mlps_pkg::ST_OUT && state_next == mlps_pkg::ST_IDLE)
                out_valid_reg <= 1'b1;
            else if (out_fire)
                out_valid_reg <= 1'b0;
            // step counter and wait flag
            if (state_next != state_reg)
            begin
                div_wait_reg <= 1'b0;
                sq_reg       <= '0;
                // the color channel carries through the int, terms, acc loop
                if (state_reg == mlps_pkg::ST_ACC && state_next == mlps_pkg::ST_INT)
                    k_reg <= k_reg + 2'd1;
                else if (state_next != mlps_pkg::ST_TERMS &&
                         state_next != mlps_pkg::ST_ACC)
                    k_reg <= '0;
            end
            else
            begin
                unique case (state_reg)
                    mlps_pkg::ST_NSQ, mlps_pkg::ST_VSQ, mlps_pkg::ST_LSQ,
                    mlps_pkg::ST_HSQ:
                        k_reg <= k_reg + 2'd1;
                    mlps_pkg::ST_NLEN, mlps_pkg::ST_VLEN, mlps_pkg::ST_LLEN,
                    mlps_pkg::ST_HLEN:
                        div_wait_reg <= 1'b1;
                    mlps_pkg::ST_NDIV, mlps_pkg::ST_VDIV, mlps_pkg::ST_LDIV,
                    mlps_pkg::ST_HDIV, mlps_pkg::ST_SCALE:
                        if (dreq.start)
                            div_wait_reg <= 1'b1;
                        else if (drsp.done || (len_reg == 0 &&
                                 state_reg != mlps_pkg::ST_SCALE))
                        begin
                            div_wait_reg <= 1'b0;
                            k_reg        <= k_reg + 2'd1;
                        end
                    mlps_pkg::ST_ATT:
                        if (dreq.start) div_wait_reg <= 1'b1;
                    mlps_pkg::ST_POW:
                        sq_reg <= sq_reg + 4'd1;
                    default: ;
                endcase
            end
        end
    end

    // datapath
    logic signed [16:0] qs;
    logic div_result;
    assign qs = vcur[17] ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign div_result = (len_reg == 0) || drsp.done;

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            mlps_pkg::ST_IDLE:
                if (shade_fire)
                begin
                    frag_reg[0] <= pos_x;
                    frag_reg[1] <= pos_y;
                    frag_reg[2] <= pos_z;
                    vec_reg[0]  <= 18'(normal_x);
                    vec_reg[1]  <= 18'(normal_y);
                    vec_reg[2]  <= 18'(normal_z);
                end
            mlps_pkg::ST_PREP:
            begin
                sumsq_reg    <= '0;
                total_reg[0] <= 41'(obj_reg[0]) << 1;
                total_reg[1] <= 41'(obj_reg[1]) << 1;
                total_reg[2] <= 41'(obj_reg[2]) << 1;
            end
            mlps_pkg::ST_NSQ, mlps_pkg::ST_VSQ, mlps_pkg::ST_LSQ, mlps_pkg::ST_HSQ:
                sumsq_reg <= sumsq_reg + 36'(mag_cur * mag_cur);
            mlps_pkg::ST_NLEN, mlps_pkg::ST_VLEN, mlps_pkg::ST_LLEN, mlps_pkg::ST_HLEN:
            begin
                len_reg <= srsp.root;
                if (state_reg == mlps_pkg::ST_LLEN)
                    dsq_reg <= 35'(sumsq_reg);
            end
            mlps_pkg::ST_NDIV, mlps_pkg::ST_VDIV, mlps_pkg::ST_LDIV, mlps_pkg::ST_HDIV:
                if (div_result && !dreq.start && (div_wait_reg || len_reg == 0))
                begin
                    tmp_reg[k_reg] <= (len_reg == 0) ? 16'sd0 : qs[15:0];
                    if (k_reg == 2'd2)
                    begin
                        sumsq_reg <= '0;
                        if (state_reg == mlps_pkg::ST_NDIV)
                        begin
                            nu_reg[0] <= tmp_reg[0];
                            nu_reg[1] <= tmp_reg[1];
                            nu_reg[2] <= (len_reg == 0) ? 16'sd0 : qs[15:0];
                            vec_reg[0] <= 18'(cam_reg[0]) - 18'(frag_reg[0]);
                            vec_reg[1] <= 18'(cam_reg[1]) - 18'(frag_reg[1]);
                            vec_reg[2] <= 18'(cam_reg[2]) - 18'(frag_reg[2]);
                        end
                        else if (state_reg == mlps_pkg::ST_VDIV)
                        begin
                            vu_reg[0] <= tmp_reg[0];
                            vu_reg[1] <= tmp_reg[1];
                            vu_reg[2] <= (len_reg == 0) ? 16'sd0 : qs[15:0];
                        end
                        else if (state_reg == mlps_pkg::ST_LDIV)
                        begin
                            lu_reg[0] <= tmp_reg[0];
                            lu_reg[1] <= tmp_reg[1];
                            lu_reg[2] <= (len_reg == 0) ? 16'sd0 : qs[15:0];
                        end
                        else
                        begin
                            hu_reg[0] <= tmp_reg[0];
                            hu_reg[1] <= tmp_reg[1];
                            hu_reg[2] <= (len_reg == 0) ? 16'sd0 : qs[15:0];
                        end
                    end
                end
            mlps_pkg::ST_LDIFF:
            begin
                vec_reg[0] <= 18'(signed'(pos_rd[47:32])) - 18'(frag_reg[0]);
                vec_reg[1] <= 18'(signed'(pos_rd[31:16])) - 18'(frag_reg[1]);
                vec_reg[2] <= 18'(signed'(pos_rd[15:0]))  - 18'(frag_reg[2]);
                lcol_reg   <= col_rd;
                lrad_reg   <= rad_rd;
                sumsq_reg  <= '0;
            end
            mlps_pkg::ST_ATT:
                if (dsq_reg == 0)
                    att_reg <= (lrad_reg == 0) ? 32'd0 : 32'hFFFF_FFFF;
                else if (drsp.done)
                    att_reg <= (drsp.quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF
                                                           : drsp.quot[31:0];
            mlps_pkg::ST_HSUM:
            begin
                vec_reg[0] <= 18'(lu_reg[0]) + 18'(vu_reg[0]);
                vec_reg[1] <= 18'(lu_reg[1]) + 18'(vu_reg[1]);
                vec_reg[2] <= 18'(lu_reg[2]) + 18'(vu_reg[2]);
                sumsq_reg  <= '0;
            end
            mlps_pkg::ST_DOTS:
            begin
                angle_reg <= (dot_nl > 0) ? 18'(dot_nl >>> 14) : 18'd0;
                if (dot_nh <= 0)
                    blinn_reg <= '0;
                else if ((dot_nh >>> 14) >= 34'sd16384)
                    blinn_reg <= 15'd16384;
                else
                    blinn_reg <= 15'(dot_nh >>> 14);
            end
            mlps_pkg::ST_POW:
                if (sq_reg != 4'd9)
                    blinn_reg <= 15'((30'(blinn_reg) * 30'(blinn_reg)) >> 14);
            mlps_pkg::ST_INT:
                inten_reg[k_reg] <= 50'(((49'(lcol_k) + 49'(obj_k)) * 49'(att_reg)) >> 15);
            mlps_pkg::ST_TERMS:
                prod_reg <= 64'((65'(inten_reg[k_reg]) * 65'(blinn_reg)) >> 14);
            mlps_pkg::ST_ACC:
                total_reg[k_reg] <= total_reg[k_reg]
                    + 41'((68'(inten_reg[k_reg]) * 68'(angle_reg)) >> 14)
                    + 41'((80'(prod_reg) * 80'(lcol_k)) >> 15);
            mlps_pkg::ST_SCALE:
                if (drsp.done)
                    pix_reg[k_reg] <= (drsp.quot > 64'd255) ? 8'd255 : drsp.quot[7:0];
            default: ;
        endcase
    end

    // result register
    logic [7:0] res_reg [3];
    always_ff @(posedge clk)
    begin
        if (state_reg == mlps_pkg::ST_OUT && state_next == mlps_pkg::ST_IDLE)
        begin
            res_reg[0] <= pix_reg[0];
            res_reg[1] <= pix_reg[1];
            res_reg[2] <= pix_reg[2];
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_red   = res_reg[0];
    assign pixel_green = res_reg[1];
    assign pixel_blue  = res_reg[2];

`ifndef SYNTHESIS
    // a load beat never starts the shading sequence
    assert property (@(posedge clk) disable iff (!rst_n)
        load_fire |=> state_reg == mlps_pkg::ST_IDLE)
        else $error("load beat left idle");

    // the divider is never restarted while it still iterates
    assert property (@(posedge clk) disable iff (!rst_n)
        drsp.busy |-> !dreq.start)
        else $error("divider restarted while busy");

    // the light walk never passes the configured count
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == mlps_pkg::ST_RD |-> li_reg < nlights)
        else $error("light index beyond count");

    // a held result stays until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_red))
        else $error("result dropped");
`endif

endmodule
`default_nettype wire

@@ sim/tb_multi_light_pixel_shader.sv @@
`timescale 1ns / 1ps
module tb_multi_light_pixel_shader;

    localparam int TABLE_DEPTH = 8;
    localparam int CYCLE_LIMIT = 10000000;
    localparam int SETTLE      = 20;

    typedef struct {
        logic        kind;
        logic [2:0]  idx;
        logic [15:0] px, py, pz;
        logic [15:0] lr, lg, lb, reach;
        logic [15:0] nx, ny, nz;
    } beat_t;

    typedef struct {
        logic [7:0] r, g, b;
    } pixel_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        kind = 1'b0;
    logic [2:0]  light_index = '0;
    logic signed [15:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic [15:0] light_red = '0, light_green = '0, light_blue = '0, light_reach = '0;
    logic signed [15:0] normal_x = '0, normal_y = '0, normal_z = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  pixel_red, pixel_green, pixel_blue;

    // shadow of the light table and registers
    longint          lt_pos [TABLE_DEPTH][3];
    longint unsigned lt_col [TABLE_DEPTH][3];
    longint unsigned lt_rad [TABLE_DEPTH];
    longint unsigned obj_col [3];
    longint          cam_pos [3];
    int unsigned     lights_used;

    pixel_t pixel_q[$];
    int     errors = 0;
    int     cycles = 0;
    bit     sender_burst = 0;
    int     ready_hold = 0;

    multi_light_pixel_shader i_dut (.*);

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(15, 60);
    endfunction

    // output stall pattern
    always @(posedge clk)
    begin
        if (ready_hold > 0)
        begin
            ready_hold--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
                ready_hold = gap_len();
        end
    end

    // result check
    always @(posedge clk)
    begin
        pixel_t want;
        if (out_valid && out_ready)
        begin
            if (pixel_q.size() == 0)
            begin
                $error("pixel beat with no expected pixel");
                errors++;
            end
            else
            begin
                want = pixel_q.pop_front();
                if (pixel_red !== want.r)
                begin
                    $error("pixel_red expected %0d actual %0d", want.r, pixel_red);
                    errors++;
                end
                if (pixel_green !== want.g)
                begin
                    $error("pixel_green expected %0d actual %0d", want.g, pixel_green);
                    errors++;
                end
                if (pixel_blue !== want.b)
                begin
                    $error("pixel_blue expected %0d actual %0d", want.b, pixel_blue);
                    errors++;
                end
            end
        end
    end

    function automatic longint unsigned magnitude(longint c);
        return c < 0 ? longint'(-c) : c;
    endfunction

    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > x)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (x >= res + bitv)
            begin
                x -= res + bitv;
                res = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // Q2.14 unit vector, zero vector stays zero
    function automatic void unit_vec(input longint v[3], output longint u[3]);
        longint unsigned sum, len, q;
        sum = 0;
        for (int k = 0; k < 3; k++)
            sum += magnitude(v[k]) * magnitude(v[k]);
        len = int_sqrt(sum);
        for (int k = 0; k < 3; k++)
        begin
            if (len == 0)
                u[k] = 0;
            else
            begin
                q = (magnitude(v[k]) << 14) / len;
                u[k] = v[k] < 0 ? -longint'(q) : longint'(q);
            end
        end
    endfunction

    function automatic longint dot_vec(longint a[3], longint b[3]);
        return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    // blinn-phong color of one fragment over the table
    function automatic pixel_t shade_fragment(beat_t bt);
        longint frag[3], nrm[3], view[3], nu[3], vu[3];
        longint lv[3], lu[3], hs[3], hu[3];
        longint unsigned total[3];
        longint unsigned n, dsq, att, angle, blinn, inten, spec, p;
        longint d;
        pixel_t px;
        frag[0] = longint'($signed(bt.px));
        frag[1] = longint'($signed(bt.py));
        frag[2] = longint'($signed(bt.pz));
        nrm[0] = longint'($signed(bt.nx));
        nrm[1] = longint'($signed(bt.ny));
        nrm[2] = longint'($signed(bt.nz));
        n = lights_used == 0 ? 1 : (lights_used > TABLE_DEPTH ? TABLE_DEPTH : lights_used);
        for (int k = 0; k < 3; k++)
        begin
            view[k] = cam_pos[k] - frag[k];
            total[k] = obj_col[k] << 1;
        end
        unit_vec(nrm, nu);
        unit_vec(view, vu);
        for (int i = 0; i < n; i++)
        begin
            dsq = 0;
            for (int k = 0; k < 3; k++)
            begin
                lv[k] = lt_pos[i][k] - frag[k];
                dsq += magnitude(lv[k]) * magnitude(lv[k]);
            end
            unit_vec(lv, lu);
            if (dsq == 0)
                att = lt_rad[i] == 0 ? 0 : 64'hFFFF_FFFF;
            else
            begin
                att = (lt_rad[i] << 24) / dsq;
                if (att > 64'hFFFF_FFFF)
                    att = 64'hFFFF_FFFF;
            end
            d = dot_vec(nu, lu);
            angle = d > 0 ? longint'(d) >> 14 : 0;
            for (int k = 0; k < 3; k++)
                hs[k] = lu[k] + vu[k];
            unit_vec(hs, hu);
            d = dot_vec(nu, hu);
            blinn = d > 0 ? longint'(d) >> 14 : 0;
            if (blinn > 16384)
                blinn = 16384;
            // exponent 512
            for (int s = 0; s < 9; s++)
                blinn = (blinn * blinn) >> 14;
            for (int k = 0; k < 3; k++)
            begin
                inten = ((lt_col[i][k] + obj_col[k]) * att) >> 15;
                spec = (((inten * blinn) >> 14) * lt_col[i][k]) >> 15;
                total[k] += ((inten * angle) >> 14) + spec;
            end
        end
        for (int k = 0; k < 3; k++)
        begin
            p = (total[k] * 255) / (n << 16);
            if (p > 255)
                p = 255;
            if (k == 0)
                px.r = p[7:0];
            else if (k == 1)
                px.g = p[7:0];
            else
                px.b = p[7:0];
        end
        return px;
    endfunction

    task automatic set_reg(mlps_pkg::reg_index_t r, logic [15:0] v);
        cfg_we <= 1'b1;
        cfg_index <= r[2:0];
        cfg_data <= v;
        case (r)
            mlps_pkg::REG_OBJ_R:  obj_col[0] = v;
            mlps_pkg::REG_OBJ_G:  obj_col[1] = v;
            mlps_pkg::REG_OBJ_B:  obj_col[2] = v;
            mlps_pkg::REG_CAM_X:  cam_pos[0] = longint'($signed(v));
            mlps_pkg::REG_CAM_Y:  cam_pos[1] = longint'($signed(v));
            mlps_pkg::REG_CAM_Z:  cam_pos[2] = longint'($signed(v));
            mlps_pkg::REG_LCOUNT: lights_used = v[3:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // block idle before register writes
    task automatic drain();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic send_beat(beat_t bt);
        int gap;
        gap = sender_burst ? 0 : gap_len();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= bt.kind;
        light_index <= bt.idx;
        pos_x <= bt.px;
        pos_y <= bt.py;
        pos_z <= bt.pz;
        light_red <= bt.lr;
        light_green <= bt.lg;
        light_blue <= bt.lb;
        light_reach <= bt.reach;
        normal_x <= bt.nx;
        normal_y <= bt.ny;
        normal_z <= bt.nz;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // accepted at this edge
        if (bt.kind == mlps_pkg::KIND_LOAD)
        begin
            lt_pos[bt.idx][0] = longint'($signed(bt.px));
            lt_pos[bt.idx][1] = longint'($signed(bt.py));
            lt_pos[bt.idx][2] = longint'($signed(bt.pz));
            lt_col[bt.idx][0] = bt.lr;
            lt_col[bt.idx][1] = bt.lg;
            lt_col[bt.idx][2] = bt.lb;
            lt_rad[bt.idx] = bt.reach;
        end
        else
            pixel_q.push_back(shade_fragment(bt));
    endtask

    function automatic logic [15:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(0, 4096)) - 2048);
            2: return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return 16'($signed($urandom_range(0, 512)) - 256);
        endcase
    endfunction

    function automatic beat_t rand_beat(logic k);
        beat_t bt;
        bt.kind = k;
        bt.idx = 3'($urandom);
        bt.px = rand_coord();
        bt.py = rand_coord();
        bt.pz = rand_coord();
        bt.lr = 16'($urandom);
        bt.lg = 16'($urandom);
        bt.lb = 16'($urandom);
        bt.reach = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(0, 2048));
        if ($urandom_range(0, 2) == 0)
        begin
            bt.nx = 16'($urandom);
            bt.ny = 16'($urandom);
            bt.nz = 16'($urandom);
        end
        else
        begin
            bt.nx = 16'($signed($urandom_range(0, 32768)) - 16384);
            bt.ny = 16'($signed($urandom_range(0, 32768)) - 16384);
            bt.nz = 16'($signed($urandom_range(0, 32768)) - 16384);
        end
        return bt;
    endfunction

    function automatic beat_t load_beat(int i, logic [15:0] x, logic [15:0] y,
                                        logic [15:0] z, logic [15:0] c, logic [15:0] rad);
        beat_t bt;
        bt = rand_beat(mlps_pkg::KIND_LOAD);
        bt.idx = 3'(i);
        bt.px = x;
        bt.py = y;
        bt.pz = z;
        bt.lr = c;
        bt.lg = c;
        bt.lb = c;
        bt.reach = rad;
        return bt;
    endfunction

    // fill every table entry, with extreme entries
    task automatic test_table_load();
        beat_t bt;
        send_beat(load_beat(0, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h0100));
        send_beat(load_beat(1, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF));
        send_beat(load_beat(2, 16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000));
        for (int i = 3; i < TABLE_DEPTH; i++)
        begin
            bt = rand_beat(mlps_pkg::KIND_LOAD);
            bt.idx = 3'(i);
            send_beat(bt);
        end
    endtask

    // corner fragments
    task automatic test_directed_shades();
        beat_t bt;
        drain();
        set_reg(mlps_pkg::REG_LCOUNT, 16'd3);
        // zero normal
        bt = rand_beat(mlps_pkg::KIND_SHADE);
        bt.nx = 0; bt.ny = 0; bt.nz = 0;
        send_beat(bt);
        // fragment on light 0: zero distance
        bt = rand_beat(mlps_pkg::KIND_SHADE);
        bt.px = 0; bt.py = 0; bt.pz = 0; bt.nz = 16'h4000;
        send_beat(bt);
        // fragment on zero radius light
        bt.px = 16'h8000; bt.py = 16'h8000; bt.pz = 16'h8000;
        send_beat(bt);
        // fragment at the camera: zero view vector
        bt = rand_beat(mlps_pkg::KIND_SHADE);
        bt.px = 0; bt.py = 0; bt.pz = 0;
        send_beat(bt);
        // extreme normals and positions
        bt = rand_beat(mlps_pkg::KIND_SHADE);
        bt.px = 16'h7FFF; bt.py = 16'h8000; bt.pz = 16'h7FFF;
        bt.nx = 16'h7FFF; bt.ny = 16'h8000; bt.nz = 16'h7FFF;
        send_beat(bt);
        bt.nx = 16'h8000; bt.ny = 16'h8000; bt.nz = 16'h8000;
        bt.px = 16'h8000; bt.py = 16'h7FFF; bt.pz = 16'h0000;
        send_beat(bt);
    endtask

    // register extremes, light_count zero and above the table size
    task automatic test_register_extremes();
        drain();
        set_reg(mlps_pkg::REG_OBJ_R, 16'h0000);
        set_reg(mlps_pkg::REG_OBJ_G, 16'hFFFF);
        set_reg(mlps_pkg::REG_OBJ_B, 16'h0000);
        set_reg(mlps_pkg::REG_CAM_X, 16'h7FFF);
        set_reg(mlps_pkg::REG_CAM_Y, 16'h8000);
        set_reg(mlps_pkg::REG_CAM_Z, 16'h7FFF);
        set_reg(mlps_pkg::REG_LCOUNT, 16'd0);
        send_beat(rand_beat(mlps_pkg::KIND_SHADE));
        send_beat(rand_beat(mlps_pkg::KIND_SHADE));
        drain();
        set_reg(mlps_pkg::REG_OBJ_R, 16'hFFFF);
        set_reg(mlps_pkg::REG_OBJ_G, 16'h0000);
        set_reg(mlps_pkg::REG_OBJ_B, 16'hFFFF);
        set_reg(mlps_pkg::REG_CAM_X, 16'h8000);
        set_reg(mlps_pkg::REG_CAM_Y, 16'h7FFF);
        set_reg(mlps_pkg::REG_CAM_Z, 16'h8000);
        set_reg(mlps_pkg::REG_LCOUNT, 16'd15);
        send_beat(rand_beat(mlps_pkg::KIND_SHADE));
        drain();
        set_reg(mlps_pkg::REG_LCOUNT, 16'd8);
        send_beat(rand_beat(mlps_pkg::KIND_SHADE));
    endtask

    // random phases with mixed register settings
    task automatic test_random_traffic();
        int lc;
        for (int ph = 0; ph < 10; ph++)
        begin
            drain();
            sender_burst = ph % 3 == 1;
            set_reg(mlps_pkg::REG_OBJ_R, 16'($urandom));
            set_reg(mlps_pkg::REG_OBJ_G, 16'($urandom));
            set_reg(mlps_pkg::REG_OBJ_B, 16'($urandom));
            set_reg(mlps_pkg::REG_CAM_X, rand_coord());
            set_reg(mlps_pkg::REG_CAM_Y, rand_coord());
            set_reg(mlps_pkg::REG_CAM_Z, rand_coord());
            lc = ph == 4 ? 8 : (ph == 7 ? $urandom_range(9, 15) : $urandom_range(1, 2));
            set_reg(mlps_pkg::REG_LCOUNT, 16'(lc));
            for (int j = 0; j < 38; j++)
            begin
                send_beat(rand_beat($urandom_range(0, 3) != 0 ? mlps_pkg::KIND_SHADE
                                                              : mlps_pkg::KIND_LOAD));
                // hold off until the pipe empties
                if (j == 20 && ph == 2)
                begin
                    in_valid <= 1'b0;
                    @(posedge clk);
                    while (pixel_q.size() != 0)
                        @(posedge clk);
                end
            end
        end
        sender_burst = 0;
    endtask

    initial
    begin
        obj_col = '{32768, 32768, 32768};
        cam_pos = '{0, 0, 0};
        lights_used = 1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_table_load();
        test_directed_shades();
        test_register_extremes();
        test_random_traffic();
        in_valid <= 1'b0;
        while (pixel_q.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

@@ filelist.f @@
design/mlps_pkg.sv
design/mlps_ram.sv
design/mlps_div.sv
design/mlps_sqrt.sv
design/multi_light_pixel_shader.sv
sim/tb_multi_light_pixel_shader.sv
